// File: rtl/core/chit_pkg.sv
// chit_pkg: shared constants, codes and types of the chained hash index table
// used by chit_bucket_mod and chained_hash_index_table_top; no dependencies
package chit_pkg;

    // fixed field widths of the stream payload
    localparam int OP_W     = 2;
    localparam int KEY_W    = 48;
    localparam int EIDX_W   = 10;
    localparam int STATUS_W = 2;
    localparam int RIDX_W   = 10;
    localparam int TDATA_W  = 64;

    // default sizing
    localparam int DEF_ENTRIES  = 1024;
    localparam int DEF_BUCKETS  = 128;
    localparam int DEF_KEY_BITS = 48;

    // operation codes
    localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_FETCH  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    // status of the bucket remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } chit_mod_stat_t;

endpackage

// File: rtl/core/chained_hash_index_table_top.sv
// chained_hash_index_table_top: sequencer, key/link/bucket-head memories
// depends on chit_pkg, chit_ram and chit_bucket_mod
//
// Interning table: insert appends a key at the next free index and links it at
// the head of bucket (key mod BUCKETS); find walks that chain newest first and
// returns the first matching index; fetch returns the key at an index. After
// reset the block clears the bucket heads, one per cycle, and takes no
// transaction meanwhile. One transaction is worked at a time: the bucket
// number comes from a mask when BUCKETS is a power of two and otherwise from
// a serial remainder unit, four key bits per cycle. A find then reads the
// bucket head and walks the chain, one chain entry per read of the key and
// link memories; an insert writes the bucket head and the entry; a fetch reads
// the key memory. A result waiting at the output does not block the next
// transaction from being accepted.
module chained_hash_index_table_top #(
    parameter int ENTRIES  = chit_pkg::DEF_ENTRIES,
    parameter int BUCKETS  = chit_pkg::DEF_BUCKETS,
    parameter int KEY_BITS = chit_pkg::DEF_KEY_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // op[1:0], key[49:2], entry_index[59:50], zero fill
    input  logic [chit_pkg::TDATA_W-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // status[1:0], result_index[11:2], result_key[59:12], zero fill
    output logic [chit_pkg::TDATA_W-1:0] m_axis_tdata
);

    import chit_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int LINK_W = IDX_W + 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int BKT_AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [LINK_W-1:0] EMPTY_LINK = {1'b1, {IDX_W{1'b0}}};

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_HEAD  = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_FETCH = 3'd5;
    localparam logic [2:0] S_PUSH  = 3'd6;

    // payload fields
    logic [OP_W-1:0]   in_op;
    logic [KEY_W-1:0]  in_key;
    logic [EIDX_W-1:0] in_eidx;
    logic [63:0]       in_key_ext;
    logic [KEY_BITS-1:0] in_key_m;
    logic [31:0]       fidx_ext;
    logic [31:0]       cnt_ext;
    logic [31:0]       cur_ext;
    logic [63:0]       stored_key_ext;

    // control and payload registers
    logic [2:0]          state_reg, state_next;
    logic [BKT_AW-1:0]   clr_reg, clr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [BKT_AW-1:0]   bkt_reg, bkt_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [RIDX_W-1:0]   res_index_reg, res_index_next;
    logic [KEY_W-1:0]    res_key_reg, res_key_next;
    logic                out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0]  out_data_reg, out_data_next;

    // memory ports
    logic                head_we, head_re;
    logic [BKT_AW-1:0]   head_waddr;
    logic [LINK_W-1:0]   head_wdata, head_rdata;
    logic                ent_we, ent_re;
    logic [IDX_W-1:0]    ent_waddr, ent_raddr;
    logic [KEY_BITS-1:0] key_rdata;
    logic [LINK_W-1:0]   link_rdata;

    // bucket unit
    logic                mod_start;
    logic [BKT_AW-1:0]   mod_bucket;
    chit_mod_stat_t      mod_stat;

    logic in_fire;
    logic full;

    assign in_op      = s_axis_tdata[1:0];
    assign in_key     = s_axis_tdata[49:2];
    assign in_eidx    = s_axis_tdata[59:50];
    assign in_key_ext = 64'(in_key);
    assign in_key_m   = in_key_ext[KEY_BITS-1:0];
    assign fidx_ext   = 32'(in_eidx);
    assign cnt_ext    = 32'(cnt_reg);
    assign cur_ext    = 32'(cur_reg);
    assign stored_key_ext = 64'(key_rdata);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign full          = (cnt_reg == CNT_W'(ENTRIES));
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign mod_start = in_fire && (in_op == OP_FIND || in_op == OP_INSERT);

    // bucket heads: cleared after reset, rewritten on insert
    assign head_we    = (state_reg == S_CLEAR) ||
                        (state_reg == S_HEAD && op_reg == OP_INSERT);
    assign head_waddr = (state_reg == S_CLEAR) ? clr_reg : bkt_reg;
    assign head_wdata = (state_reg == S_CLEAR) ? EMPTY_LINK
                                               : {1'b0, cnt_reg[IDX_W-1:0]};
    assign head_re    = (state_reg == S_MOD) && mod_stat.done;

    assign ent_we    = (state_reg == S_HEAD) && (op_reg == OP_INSERT);
    assign ent_waddr = cnt_reg[IDX_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        bkt_next        = bkt_reg;
        cur_next        = cur_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_key_next    = res_key_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        ent_re          = 1'b0;
        ent_raddr       = cur_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == BKT_AW'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next         = in_op;
                    key_next        = in_key_m;
                    cur_next        = fidx_ext[IDX_W-1:0];
                    res_status_next = ST_RANGE;
                    res_index_next  = '0;
                    res_key_next    = '0;
                    case (in_op)
                        OP_FIND, OP_INSERT:
                        begin
                            state_next = S_MOD;
                        end
                        OP_FETCH:
                        begin
                            if (fidx_ext >= cnt_ext)
                            begin
                                state_next = S_PUSH;
                            end
                            else
                            begin
                                ent_re     = 1'b1;
                                ent_raddr  = fidx_ext[IDX_W-1:0];
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_PUSH;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                if (mod_stat.done)
                begin
                    bkt_next = mod_bucket;
                    if (op_reg == OP_INSERT && full)
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_PUSH;
                    end
                    else
                    begin
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD:
            begin
                if (op_reg == OP_INSERT)
                begin
                    res_status_next = ST_OK;
                    res_index_next  = cnt_ext[RIDX_W-1:0];
                    cnt_next        = cnt_reg + 1'b1;
                    state_next      = S_PUSH;
                end
                else if (head_rdata[IDX_W])
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_PUSH;
                end
                else
                begin
                    ent_re     = 1'b1;
                    ent_raddr  = head_rdata[IDX_W-1:0];
                    cur_next   = head_rdata[IDX_W-1:0];
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                // one chain entry per cycle: compare and issue the next read
                if (key_rdata == key_reg)
                begin
                    res_status_next = ST_OK;
                    res_index_next  = cur_ext[RIDX_W-1:0];
                    state_next      = S_PUSH;
                end
                else if (link_rdata[IDX_W])
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_PUSH;
                end
                else
                begin
                    ent_re    = 1'b1;
                    ent_raddr = link_rdata[IDX_W-1:0];
                    cur_next  = link_rdata[IDX_W-1:0];
                end
            end
            S_FETCH:
            begin
                res_status_next = ST_OK;
                res_index_next  = cur_ext[RIDX_W-1:0];
                res_key_next    = stored_key_ext[KEY_W-1:0];
                state_next      = S_PUSH;
            end
            S_PUSH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'b0, res_key_reg, res_index_reg, res_status_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        bkt_reg        <= bkt_next;
        cur_reg        <= cur_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_key_reg    <= res_key_next;
        out_data_reg   <= out_data_next;
    end

    chit_bucket_mod #(
        .BUCKETS  (BUCKETS),
        .KEY_BITS (KEY_BITS),
        .BKT_AW   (BKT_AW)
    ) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .key    (in_key_m),
        .bucket (mod_bucket),
        .stat   (mod_stat)
    );

    chit_ram #(
        .WIDTH (LINK_W),
        .DEPTH (BUCKETS),
        .AW    (BKT_AW)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (head_re),
        .raddr (mod_bucket),
        .rdata (head_rdata)
    );

    chit_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_key_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (key_reg),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (key_rdata)
    );

    chit_ram #(
        .WIDTH (LINK_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_link_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (head_rdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (link_rdata)
    );

    // entry count never passes the table size
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ENTRIES))
        else $error("entry count beyond table size");

    // the count moves only on a completed insert
    a_cnt_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
        ($past(state_reg) == S_HEAD && $past(op_reg) == OP_INSERT))
        else $error("entry count changed outside an insert");

    // a chain walk only visits written entries
    a_walk_written: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (cur_ext < cnt_ext))
        else $error("chain walk reached an unwritten entry");

    // the remainder unit works only for the transaction in flight
    a_mod_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (mod_stat.done || mod_stat.busy) |-> (state_reg == S_MOD))
        else $error("bucket unit active outside bucket state");

    // one transaction at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("second transaction accepted while busy");

endmodule

// File: rtl/core/chit_ram.sv
// chit_ram: generic simple dual-port ram, one write port, one read port,
// registered read data that holds while no read is issued; no dependencies
module chit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/chit_bucket_mod.sv
// chit_bucket_mod: bucket number = key mod BUCKETS; a mask for a power of two,
// otherwise a radix-16 compare and subtract remainder, four key bits per cycle; uses chit_pkg
module chit_bucket_mod #(
    parameter int BUCKETS  = 128,
    parameter int KEY_BITS = 48,
    parameter int BKT_AW   = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [KEY_BITS-1:0]     key,
    output logic [BKT_AW-1:0]       bucket,
    output chit_pkg::chit_mod_stat_t stat
);

    import chit_pkg::*;

    localparam bit BKT_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    logic [BKT_AW-1:0] rem_reg;
    logic              done_reg;
    logic              mod_busy;

    assign bucket = rem_reg;
    assign stat   = '{busy: mod_busy, done: done_reg};

    if (BKT_POW2)
    begin : g_mask
        logic [KEY_BITS-1:0] masked;

        assign masked   = key & KEY_BITS'(BUCKETS - 1);
        assign mod_busy = 1'b0;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                done_reg <= 1'b0;
            end
            else
            begin
                done_reg <= start;
            end
        end

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                rem_reg <= BKT_AW'(masked);
            end
        end
    end
    else
    begin : g_serial
        localparam int DIG_W = 4;
        localparam int STEPS = (KEY_BITS + DIG_W - 1) / DIG_W;
        localparam int PAD_W = STEPS * DIG_W;
        localparam int TRY_W = BKT_AW + DIG_W;
        localparam int KC_W  = $clog2(STEPS + 1);

        logic [PAD_W-1:0] shift_reg;
        logic [KC_W-1:0]  cnt_reg;
        logic             busy_reg;
        logic [TRY_W-1:0] trial;
        logic [TRY_W-1:0] reduced;

        assign trial    = {rem_reg, shift_reg[PAD_W-1 -: DIG_W]};
        assign mod_busy = busy_reg;

        // shift in the next key digit, take off the largest multiple of the modulus
        always_comb
        begin
            reduced = trial;
            for (int m = 1; m < (1 << DIG_W); m++)
            begin
                if (trial >= TRY_W'(m * BUCKETS))
                begin
                    reduced = trial - TRY_W'(m * BUCKETS);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else
            begin
                done_reg <= 1'b0;
                if (start)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= KC_W'(STEPS);
                end
                else if (busy_reg)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == KC_W'(1))
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                rem_reg   <= '0;
                shift_reg <= PAD_W'(key);
            end
            else if (busy_reg)
            begin
                rem_reg   <= reduced[BKT_AW-1:0];
                shift_reg <= shift_reg << DIG_W;
            end
        end
    end

endmodule
